/* sv/vps_pkg.sv */
`timescale 1ns / 1ps
package vps_pkg;

	localparam int DATA_W     = 32;
	localparam int CFG_W      = 64;
	localparam int CFG_ADDR_W = 3;
	localparam int SCR_W      = 14;

	// Quotient bits of the viewport offset; the offset magnitude is capped at 2^40.
	localparam int QBITS = 41;
	localparam int OFF_W = QBITS + 1;
	localparam int SUM_W = 44;

	localparam int CLIP_LAT = 3;
	localparam int DIV_LAT  = QBITS + 5;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_XROW_A  = 3'd0,
		REG_XROW_B  = 3'd1,
		REG_YROW_A  = 3'd2,
		REG_YROW_B  = 3'd3,
		REG_WROW_A  = 3'd4,
		REG_WROW_B  = 3'd5,
		REG_SCR_W   = 3'd6,
		REG_SCR_H   = 3'd7
	} cfg_reg_t;

	typedef logic signed [DATA_W-1:0] fix_t;

endpackage

/* sv/view_projection_to_screen.sv */
`timescale 1ns / 1ps
// Projects one world point per clock to screen coordinates. A transaction is taken
// whenever start is high; busy is always low. The receiver cannot hold results off, so
// the pipeline never stalls. Each result is on the outputs with done high for one cycle,
// in order. The pipeline has fifty register stages, and the first one loads at the
// accepting edge: three stages of matrix products and sums, 46 stages of multiply and
// a pipelined restoring divide whose step stages yield one quotient bit each, and one
// stage of final offset, saturation and flags. Configuration writes take effect at
// once and must only happen while no point is in flight.
module view_projection_to_screen #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  vps_pkg::fix_t                     pos_x,
	input  vps_pkg::fix_t                     pos_y,
	input  vps_pkg::fix_t                     pos_z,
	input  logic                              cfg_we,
	input  logic [vps_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [vps_pkg::CFG_W-1:0]         cfg_wdata,
	output logic                              done,
	output vps_pkg::fix_t                     screen_x,
	output vps_pkg::fix_t                     screen_y,
	output vps_pkg::fix_t                     depth_w,
	output logic                              in_front,
	output logic                              div_zero
);
	import vps_pkg::*;

	localparam int CW  = 66 - FRAC_BITS;
	localparam int LAT = CLIP_LAT + DIV_LAT;
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [CW-1:0]    ONE  = CW'(1) << FRAC_BITS;
	localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

	logic [CFG_W-1:0] xrow_a_q, xrow_b_q, yrow_a_q, yrow_b_q, wrow_a_q, wrow_b_q;
	logic [SCR_W-1:0] scr_w_q, scr_h_q;

	logic                     valid_s [0:LAT-1];
	logic signed [CW-1:0]     cx, cy, cw;
	logic signed [CW-1:0]     cw_d   [0:DIV_LAT-1];
	logic [1:0]               cxs_d  [0:DIV_LAT-1];
	logic [1:0]               cys_d  [0:DIV_LAT-1];
	logic signed [OFF_W-1:0]  off_x, off_y;

	logic signed [CW-1:0]     cw_f;
	logic signed [SUM_W-1:0]  wscale, hscale, sx_sum, sy_sum;
	logic                     wzero;
	fix_t                     sx_c, sy_c;

	function automatic fix_t sat_sum(input logic signed [SUM_W-1:0] v);
		if (v[SUM_W-1:DATA_W-1] == '0 || v[SUM_W-1:DATA_W-1] == '1) begin
			return v[DATA_W-1:0];
		end
		return v[SUM_W-1] ? SMIN : SMAX;
	endfunction

	function automatic fix_t sat_clip(input logic signed [CW-1:0] v);
		if (v[CW-1:DATA_W-1] == '0 || v[CW-1:DATA_W-1] == '1) begin
			return v[DATA_W-1:0];
		end
		return v[CW-1] ? SMIN : SMAX;
	endfunction

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xrow_a_q <= 64'd65536;
			xrow_b_q <= 64'd0;
			yrow_a_q <= 64'd281474976710656;
			yrow_b_q <= 64'd0;
			wrow_a_q <= 64'd0;
			wrow_b_q <= 64'd281474976710656;
			scr_w_q  <= 14'd1920;
			scr_h_q  <= 14'd1080;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_XROW_A: xrow_a_q <= cfg_wdata;
				REG_XROW_B: xrow_b_q <= cfg_wdata;
				REG_YROW_A: yrow_a_q <= cfg_wdata;
				REG_YROW_B: yrow_b_q <= cfg_wdata;
				REG_WROW_A: wrow_a_q <= cfg_wdata;
				REG_WROW_B: wrow_b_q <= cfg_wdata;
				REG_SCR_W:  scr_w_q  <= cfg_wdata[SCR_W-1:0];
				REG_SCR_H:  scr_h_q  <= cfg_wdata[SCR_W-1:0];
				default: ;
			endcase
		end
	end

	vps_clip #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_clip_x (
		.clk(clk), .row_a(xrow_a_q), .row_b(xrow_b_q),
		.px(pos_x), .py(pos_y), .pz(pos_z), .clip(cx)
	);
	vps_clip #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_clip_y (
		.clk(clk), .row_a(yrow_a_q), .row_b(yrow_b_q),
		.px(pos_x), .py(pos_y), .pz(pos_z), .clip(cy)
	);
	vps_clip #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_clip_w (
		.clk(clk), .row_a(wrow_a_q), .row_b(wrow_b_q),
		.px(pos_x), .py(pos_y), .pz(pos_z), .clip(cw)
	);

	vps_div #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_div_x (
		.clk(clk), .num(cx), .den(cw), .scale(scr_w_q), .offset(off_x)
	);
	vps_div #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_div_y (
		.clk(clk), .num(cy), .den(cw), .scale(scr_h_q), .offset(off_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) begin
				valid_s[i] <= 1'b0;
			end
			done <= 1'b0;
		end else begin
			valid_s[0] <= start;
			for (int i = 1; i < LAT; i++) begin
				valid_s[i] <= valid_s[i-1];
			end
			done <= valid_s[LAT-1];
		end
	end

	// Sign of clip x and y (positive, negative) rides alongside the divide.
	always_ff @(posedge clk) begin
		cw_d[0]  <= cw;
		cxs_d[0] <= {!cx[CW-1] && cx != '0, cx[CW-1]};
		cys_d[0] <= {!cy[CW-1] && cy != '0, cy[CW-1]};
		for (int i = 1; i < DIV_LAT; i++) begin
			cw_d[i]  <= cw_d[i-1];
			cxs_d[i] <= cxs_d[i-1];
			cys_d[i] <= cys_d[i-1];
		end
	end

	assign cw_f   = cw_d[DIV_LAT-1];
	assign wzero  = cw_f == '0;
	assign wscale = SUM_W'(scr_w_q) << (FRAC_BITS - 1);
	assign hscale = SUM_W'(scr_h_q) << (FRAC_BITS - 1);
	assign sx_sum = wscale + {{(SUM_W-OFF_W){off_x[OFF_W-1]}}, off_x} + HALF;
	assign sy_sum = hscale - {{(SUM_W-OFF_W){off_y[OFF_W-1]}}, off_y} - HALF;

	always_comb begin
		sx_c = sat_sum(sx_sum);
		sy_c = sat_sum(sy_sum);
		if (wzero) begin
			if (cxs_d[DIV_LAT-1][1]) begin
				sx_c = SMAX;
			end else if (cxs_d[DIV_LAT-1][0]) begin
				sx_c = SMIN;
			end else begin
				sx_c = sat_sum(wscale + HALF);
			end
			if (cys_d[DIV_LAT-1][1]) begin
				sy_c = SMIN;
			end else if (cys_d[DIV_LAT-1][0]) begin
				sy_c = SMAX;
			end else begin
				sy_c = sat_sum(hscale - HALF);
			end
		end
	end

	always_ff @(posedge clk) begin
		screen_x <= sx_c;
		screen_y <= sy_c;
		depth_w  <= sat_clip(cw_f);
		in_front <= cw_f > ONE;
		div_zero <= wzero;
	end

endmodule

/* sv/vps_clip.sv */
`timescale 1ns / 1ps
module vps_clip #(
	parameter int FRAC_BITS = 16,
	parameter int CW        = 66 - FRAC_BITS
) (
	input  logic                   clk,
	input  logic [vps_pkg::CFG_W-1:0] row_a,
	input  logic [vps_pkg::CFG_W-1:0] row_b,
	input  vps_pkg::fix_t          px,
	input  vps_pkg::fix_t          py,
	input  vps_pkg::fix_t          pz,
	output logic signed [CW-1:0]   clip
);
	import vps_pkg::*;

	logic signed [63:0] p0_s1, p1_s1, p2_s1;
	fix_t               c3_s1, c3_s2;
	logic signed [64:0] sum_s2;
	logic signed [64:0] shr;

	// The floor of the exact sum equals the model's split of whole and fraction parts.
	assign shr = sum_s2 >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		p0_s1  <= $signed(row_a[31:0]) * px;
		p1_s1  <= $signed(row_a[63:32]) * py;
		p2_s1  <= $signed(row_b[31:0]) * pz;
		c3_s1  <= $signed(row_b[63:32]);
		sum_s2 <= 65'(p0_s1) + 65'(p1_s1) + 65'(p2_s1);
		c3_s2  <= c3_s1;
		clip   <= {{(CW-DATA_W){c3_s2[DATA_W-1]}}, c3_s2} + $signed(shr[CW-1:0]);
	end

endmodule

/* sv/vps_div.sv */
`timescale 1ns / 1ps
module vps_div #(
	parameter int FRAC_BITS = 16,
	parameter int CW        = 66 - FRAC_BITS
) (
	input  logic                           clk,
	input  logic signed [CW-1:0]           num,
	input  logic signed [CW-1:0]           den,
	input  logic [vps_pkg::SCR_W-1:0]      scale,
	output logic signed [vps_pkg::OFF_W-1:0] offset
);
	import vps_pkg::*;

	localparam int HI_W = CW - 32;
	localparam int A_W  = CW + SCR_W + FRAC_BITS - 1;
	localparam logic [QBITS-1:0] CAP = QBITS'(1) << (QBITS - 1);

	logic [CW-1:0]        nmag_s1, dmag_s1;
	logic                 neg_s1, neg_s2, neg_s3;
	logic [CW-1:0]        dmag_s2, dmag_s3;
	logic [SCR_W+31:0]    plo_s2;
	logic [HI_W+SCR_W-1:0] phi_s2;
	logic [A_W-1:0]       a_s3;
	logic [A_W-1:0]       a_hi;

	logic [CW-1:0]    rem_d  [0:QBITS];
	logic [CW-1:0]    dv_d   [0:QBITS];
	logic [QBITS-1:0] alo_d  [0:QBITS];
	logic [QBITS-1:0] q_d    [0:QBITS];
	logic             ovf_d  [0:QBITS];
	logic             neg_d  [0:QBITS];
	logic [QBITS-1:0] qcap;

	assign a_hi = a_s3 >> QBITS;

	always_ff @(posedge clk) begin
		nmag_s1  <= num[CW-1] ? CW'(-num) : CW'(num);
		dmag_s1  <= den[CW-1] ? CW'(-den) : CW'(den);
		neg_s1   <= num[CW-1] ^ den[CW-1];
		plo_s2   <= nmag_s1[31:0] * scale;
		phi_s2   <= nmag_s1[CW-1:32] * scale;
		dmag_s2  <= dmag_s1;
		neg_s2   <= neg_s1;
		a_s3     <= ((A_W'(phi_s2) << 32) + A_W'(plo_s2)) << (FRAC_BITS - 1);
		dmag_s3  <= dmag_s2;
		neg_s3   <= neg_s2;
		// A nonzero quotient above bit 40 means the offset saturates at the cap.
		ovf_d[0] <= a_hi >= A_W'(dmag_s3);
		rem_d[0] <= a_hi[CW-1:0];
		alo_d[0] <= a_s3[QBITS-1:0];
		dv_d[0]  <= dmag_s3;
		q_d[0]   <= '0;
		neg_d[0] <= neg_s3;
	end

	for (genvar j = 0; j < QBITS; j++) begin : g_step
		logic [CW:0] trial;
		logic [CW:0] diff;
		logic        ge;
		assign trial = {rem_d[j], alo_d[j][QBITS-1-j]};
		assign diff  = trial - {1'b0, dv_d[j]};
		assign ge    = trial >= {1'b0, dv_d[j]};
		always_ff @(posedge clk) begin
			rem_d[j+1] <= ge ? diff[CW-1:0] : trial[CW-1:0];
			q_d[j+1]   <= q_d[j] | (QBITS'(ge) << (QBITS - 1 - j));
			alo_d[j+1] <= alo_d[j];
			dv_d[j+1]  <= dv_d[j];
			ovf_d[j+1] <= ovf_d[j];
			neg_d[j+1] <= neg_d[j];
		end
	end

	assign qcap = (ovf_d[QBITS] || (q_d[QBITS][QBITS-1] && |q_d[QBITS][QBITS-2:0])) ?
		CAP : q_d[QBITS];

	always_ff @(posedge clk) begin
		offset <= neg_d[QBITS] ? -$signed({1'b0, qcap}) : $signed({1'b0, qcap});
	end

endmodule
